### rtl/core/nrm_pkg.sv
// Shared types and constants of the 3-D vector normalize unit.
// No dependencies.
package nrm_pkg;

    localparam int COMPONENT_BITS     = 16;
    localparam int UNIT_FRACTION_BITS = 14;
    localparam int UNIT_BITS          = UNIT_FRACTION_BITS + 2;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] comp_x;
        logic signed [COMPONENT_BITS-1:0] comp_y;
        logic signed [COMPONENT_BITS-1:0] comp_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [UNIT_BITS-1:0]      unit_x;
        logic signed [UNIT_BITS-1:0]      unit_y;
        logic signed [UNIT_BITS-1:0]      unit_z;
        logic        [COMPONENT_BITS-1:0] vec_length;
        logic                             zero_length;
    } t_vec_out;

endpackage

### rtl/core/nrm_sqrt_cell.sv
// One digit cell of the square root chain: one root bit per cell.
// Depends on nothing; widths come from parameters.
module nrm_sqrt_cell #(
    parameter int CB     = 16,
    parameter int SIDE_W = 49
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2*CB-1:0]   i_rad,
    input  logic [CB+1:0]     i_rem,
    input  logic [CB-1:0]     i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2*CB-1:0]   o_rad,
    output logic [CB+1:0]     o_rem,
    output logic [CB-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);
    logic              r_valid;
    logic [2*CB-1:0]   r_rad;
    logic [CB+1:0]     r_rem;
    logic [CB-1:0]     r_root;
    logic [SIDE_W-1:0] r_side;
    logic [CB+1:0]     n_rem;
    logic [CB-1:0]     n_root;
    logic [CB+1:0]     w_cur;
    logic [CB+1:0]     w_trial;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_cur   = {i_rem[CB-1:0], i_rad[2*CB-1:2*CB-2]};
        w_trial = {i_root, 2'b01};
        if (w_cur >= w_trial) begin
            n_rem  = w_cur - w_trial;
            n_root = {i_root[CB-2:0], 1'b1};
        end else begin
            n_rem  = w_cur;
            n_root = {i_root[CB-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rad  <= {i_rad[2*CB-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;
endmodule

### rtl/core/nrm_div_cell.sv
// One quotient-bit cell of the divider chain, three lanes share the divisor.
// Depends on nothing; widths come from parameters.
module nrm_div_cell #(
    parameter int CB    = 16,
    parameter int QB    = 15,
    parameter bit FIRST = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [3*(CB+1)-1:0] i_rem,
    input  logic [3*QB-1:0]   i_quo,
    input  logic [2:0]        i_neg,
    input  logic [CB-1:0]     i_len,
    input  logic              i_zero,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3*(CB+1)-1:0] o_rem,
    output logic [3*QB-1:0]   o_quo,
    output logic [2:0]        o_neg,
    output logic [CB-1:0]     o_len,
    output logic              o_zero
);
    logic                 r_valid;
    logic [3*(CB+1)-1:0]  r_rem;
    logic [3*QB-1:0]      r_quo;
    logic [2:0]           r_neg;
    logic [CB-1:0]        r_len;
    logic                 r_zero;
    logic [3*(CB+1)-1:0]  n_rem;
    logic [3*QB-1:0]      n_quo;

    assign o_ready = !r_valid || i_ready;

    // remainder stays below the divisor, so doubling fits CB+1 bits
    always_comb begin
        logic [CB:0] cur;
        logic [CB:0] dvs;
        dvs = {1'b0, i_len};
        for (int l = 0; l < 3; l++) begin
            cur = FIRST ? i_rem[l*(CB+1) +: CB+1]
                        : {i_rem[l*(CB+1) +: CB], 1'b0};
            if (cur >= dvs) begin
                n_rem[l*(CB+1) +: CB+1] = cur - dvs;
                n_quo[l*QB +: QB]       = {i_quo[l*QB +: QB-1], 1'b1};
            end else begin
                n_rem[l*(CB+1) +: CB+1] = cur;
                n_quo[l*QB +: QB]       = {i_quo[l*QB +: QB-1], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_neg  <= i_neg;
            r_len  <= i_len;
            r_zero <= i_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_neg   = r_neg;
    assign o_len   = r_len;
    assign o_zero  = r_zero;
endmodule

### rtl/core/vector3_normalize_unit.sv
// Top level of the 3-D vector normalize unit: squares, sum, root chain, divider chain.
// Depends on nrm_pkg, nrm_sqrt_cell, nrm_div_cell.
//
//  channel | dir | handshake           | payload
//  input   | in  | i_valid / o_ready   | i_data (t_vec_in)
//  result  | out | o_valid / i_ready   | o_data (t_vec_out)
//
// One vector enters per cycle while o_ready is high; the path runs through the square
// stage, the sum stage, one root cell per root bit and
// one divider cell per quotient bit.
// Each cell has its own valid bit and ready; a stalled output fills bubbles first.
// Synchronous active-low reset clears all valid bits; nothing else is kept.
module vector3_normalize_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  nrm_pkg::t_vec_in  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output nrm_pkg::t_vec_out o_data
);
    import nrm_pkg::*;

    localparam int CB     = COMPONENT_BITS;
    localparam int QB     = UNIT_FRACTION_BITS + 1;
    localparam int NDIV   = QB;
    localparam int SIDE_W = 3*CB + 1;

    // square stage
    logic                r_a_valid;
    logic [2*CB-1:0]     r_a_sq [3];
    logic [3*CB-1:0]     r_a_comp;
    logic                r_a_zero;
    // sum stage
    logic                r_b_valid;
    logic [2*CB-1:0]     r_b_sum;
    logic [3*CB-1:0]     r_b_comp;
    logic                r_b_zero;
    logic                w_rdy_a;
    logic                w_rdy_b;
    logic [CB-1:0]       w_mag [3];
    logic [3*CB-1:0]     w_comp;

    assign w_comp = {i_data.comp_x, i_data.comp_y, i_data.comp_z};

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = w_comp[l*CB+CB-1] ? (~w_comp[l*CB +: CB] + CB'(1))
                                         : w_comp[l*CB +: CB];
        end
    end

    // root chain wiring
    logic              sq_valid [CB+1];
    logic              sq_ready [CB+1];
    logic [2*CB-1:0]   sq_rad   [CB+1];
    logic [CB+1:0]     sq_rem   [CB+1];
    logic [CB-1:0]     sq_root  [CB+1];
    logic [SIDE_W-1:0] sq_side  [CB+1];

    assign w_rdy_b = !r_b_valid || sq_ready[0];
    assign w_rdy_a = !r_a_valid || w_rdy_b;
    assign o_ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_valid <= i_valid;
            end
            if (w_rdy_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            for (int l = 0; l < 3; l++) begin
                r_a_sq[l] <= (2*CB)'(w_mag[l]) * (2*CB)'(w_mag[l]);
            end
            r_a_comp <= w_comp;
            r_a_zero <= (w_comp == '0);
        end
        if (w_rdy_b && r_a_valid) begin
            r_b_sum  <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
            r_b_comp <= r_a_comp;
            r_b_zero <= r_a_zero;
        end
    end

    assign sq_valid[0] = r_b_valid;
    assign sq_rad[0]   = r_b_sum;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {r_b_comp, r_b_zero};

    for (genvar k = 0; k < CB; k++) begin : g_sqrt
        nrm_sqrt_cell #(.CB(CB), .SIDE_W(SIDE_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid[k]),
            .o_ready (sq_ready[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_valid[k+1]),
            .i_ready (sq_ready[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // divider chain wiring
    logic                dv_valid [NDIV+1];
    logic                dv_ready [NDIV+1];
    logic [3*(CB+1)-1:0] dv_rem   [NDIV+1];
    logic [3*QB-1:0]     dv_quo   [NDIV+1];
    logic [2:0]          dv_neg   [NDIV+1];
    logic [CB-1:0]       dv_len   [NDIV+1];
    logic                dv_zero  [NDIV+1];
    logic [3*CB-1:0]     w_sc;

    assign w_sc = sq_side[CB][SIDE_W-1:1];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            dv_neg[0][l] = w_sc[l*CB+CB-1];
            dv_rem[0][l*(CB+1) +: CB+1] = {1'b0, (w_sc[l*CB+CB-1]
                ? (~w_sc[l*CB +: CB] + CB'(1)) : w_sc[l*CB +: CB])};
        end
    end

    assign dv_valid[0] = sq_valid[CB];
    assign sq_ready[CB] = dv_ready[0];
    assign dv_quo[0]   = '0;
    assign dv_len[0]   = sq_root[CB];
    assign dv_zero[0]  = sq_side[CB][0];

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        nrm_div_cell #(.CB(CB), .QB(QB), .FIRST(k == 0)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_valid[k]),
            .o_ready (dv_ready[k]),
            .i_rem   (dv_rem[k]),
            .i_quo   (dv_quo[k]),
            .i_neg   (dv_neg[k]),
            .i_len   (dv_len[k]),
            .i_zero  (dv_zero[k]),
            .o_valid (dv_valid[k+1]),
            .i_ready (dv_ready[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_quo   (dv_quo[k+1]),
            .o_neg   (dv_neg[k+1]),
            .o_len   (dv_len[k+1]),
            .o_zero  (dv_zero[k+1])
        );
    end

    assign dv_ready[NDIV] = i_ready;
    assign o_valid        = dv_valid[NDIV];

    logic [UNIT_BITS-1:0] w_unit [3];
    always_comb begin
        logic [UNIT_BITS-1:0] q;
        for (int l = 0; l < 3; l++) begin
            q = {1'b0, dv_quo[NDIV][l*QB +: QB]};
            if (dv_zero[NDIV]) begin
                w_unit[l] = '0;
            end else if (dv_neg[NDIV][l]) begin
                w_unit[l] = ~q + UNIT_BITS'(1);
            end else begin
                w_unit[l] = q;
            end
        end
    end

    // lane 2 carries x, lane 0 carries z
    assign o_data.unit_x      = w_unit[2];
    assign o_data.unit_y      = w_unit[1];
    assign o_data.unit_z      = w_unit[0];
    assign o_data.vec_length  = dv_zero[NDIV] ? '0 : dv_len[NDIV];
    assign o_data.zero_length = dv_zero[NDIV];
endmodule

### rtl/core/nrm_checker.sv
// Port-level checks of the 3-D vector normalize unit, bound to the top level.
// Depends on nrm_pkg and vector3_normalize_unit.
module nrm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input nrm_pkg::t_vec_in  i_data,
    input logic              o_valid,
    input logic              i_ready,
    input nrm_pkg::t_vec_out o_data
);
    import nrm_pkg::*;

    localparam logic signed [UNIT_BITS-1:0] ONE = UNIT_BITS'(1) <<< UNIT_FRACTION_BITS;

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    // empty output means the whole chain can take a beat
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.zero_length |-> o_data.vec_length == '0
            && o_data.unit_x == '0 && o_data.unit_y == '0 && o_data.unit_z == '0)
        else $error("zero vector with nonzero fields");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.zero_length |-> o_data.vec_length != '0)
        else $error("nonzero vector with zero length");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.unit_x <= ONE && o_data.unit_x >= -ONE
            && o_data.unit_y <= ONE && o_data.unit_y >= -ONE
            && o_data.unit_z <= ONE && o_data.unit_z >= -ONE)
        else $error("unit component beyond one");
endmodule

bind vector3_normalize_unit nrm_checker u_nrm_checker (.*);

### tb/tb_vector3_normalize_unit.sv
// Self-checking testbench of vector3_normalize_unit: directed table, then random vectors,
// checked against an in-bench fixed-point predictor. Depends on nrm_pkg and the RTL.
module tb_vector3_normalize_unit;
    import nrm_pkg::*;

    localparam int LATENCY     = 2 + COMPONENT_BITS + UNIT_FRACTION_BITS + 1;
    localparam int N_RANDOM    = 650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 16;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_vec_in  i_data;
    logic     o_valid;
    logic     i_ready;
    t_vec_out o_data;

    t_vec_out expected_q[$];
    int       err_count;
    int       cycle_count;
    int       beats_in;
    int       beats_out;
    int       zero_count;
    bit       stim_done;
    bit       hold_sink;
    bit       no_idle;

    vector3_normalize_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [UNIT_BITS-1:0] scale_comp(logic signed [COMPONENT_BITS-1:0] c,
                                                       logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = c[COMPONENT_BITS-1] ? 64'(-65'(c)) : 64'(c);
        q   = (mag << UNIT_FRACTION_BITS) / len;
        if (c[COMPONENT_BITS-1]) q = -q;
        return q[UNIT_BITS-1:0];
    endfunction

    function automatic t_vec_out normalize_vec(t_vec_in v);
        t_vec_out    r;
        logic [63:0] sum;
        logic [63:0] len;
        // exact sum of squares in 64 bits
        sum = 64'($signed(v.comp_x)) * 64'($signed(v.comp_x))
            + 64'($signed(v.comp_y)) * 64'($signed(v.comp_y))
            + 64'($signed(v.comp_z)) * 64'($signed(v.comp_z));
        r = '0;
        if (sum == 0) begin
            r.zero_length = 1'b1;
        end else begin
            len          = isqrt64(sum);
            r.unit_x     = scale_comp(v.comp_x, len);
            r.unit_y     = scale_comp(v.comp_y, len);
            r.unit_z     = scale_comp(v.comp_z, len);
            r.vec_length = len[COMPONENT_BITS-1:0];
        end
        return r;
    endfunction

    // directed rows; dir_known marks rows with a result read off at a glance
    t_vec_in  dir_vec[N_DIRECTED];
    t_vec_out dir_res[N_DIRECTED];
    bit       dir_known[N_DIRECTED];

    task automatic fill_table();
        for (int k = 0; k < N_DIRECTED; k++) dir_known[k] = 1'b0;
        dir_vec[0] = '{16'sd0, 16'sd0, 16'sd0};
        dir_res[0] = '{16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1}; dir_known[0] = 1'b1;
        dir_vec[1] = '{16'sd256, 16'sd0, 16'sd0};
        dir_res[1] = '{16'sd16384, 16'sd0, 16'sd0, 16'd256, 1'b0}; dir_known[1] = 1'b1;
        dir_vec[2] = '{16'sd0, -16'sd256, 16'sd0};
        dir_res[2] = '{16'sd0, -16'sd16384, 16'sd0, 16'd256, 1'b0}; dir_known[2] = 1'b1;
        dir_vec[3] = '{16'sd0, 16'sd0, -16'sd32768};
        dir_res[3] = '{16'sd0, 16'sd0, -16'sd16384, 16'd32768, 1'b0}; dir_known[3] = 1'b1;
        dir_vec[4] = '{16'sd32767, 16'sd0, 16'sd0};
        dir_res[4] = '{16'sd16384, 16'sd0, 16'sd0, 16'd32767, 1'b0}; dir_known[4] = 1'b1;
        dir_vec[5] = '{16'sd1, 16'sd0, 16'sd0};
        dir_res[5] = '{16'sd16384, 16'sd0, 16'sd0, 16'd1, 1'b0}; dir_known[5] = 1'b1;
        dir_vec[6] = '{-16'sd32768, -16'sd32768, -16'sd32768};
        dir_vec[7] = '{16'sd32767, 16'sd32767, 16'sd32767};
        dir_vec[8] = '{-16'sd32768, 16'sd32767, -16'sd32768};
        dir_vec[9] = '{16'sd1, 16'sd1, 16'sd1};
        dir_vec[10] = '{-16'sd1, -16'sd1, -16'sd1};
        dir_vec[11] = '{16'sd768, 16'sd1024, 16'sd0};
        dir_vec[12] = '{16'sd0, 16'sd0, 16'sd0};
        dir_res[12] = '{16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1}; dir_known[12] = 1'b1;
        dir_vec[13] = '{-16'sd1, 16'sd0, 16'sd0};
        dir_res[13] = '{-16'sd16384, 16'sd0, 16'sd0, 16'd1, 1'b0}; dir_known[13] = 1'b1;
        dir_vec[14] = '{16'sd12345, -16'sd23456, 16'sd7};
        dir_vec[15] = '{16'sh5555, 16'shAAAA, 16'sh7FFE};
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 3)) - 16'd1;
            3:       return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(t_vec_in v);
        // idle gaps before offering; valid stays up until accepted
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= v;
        expected_q.push_back(normalize_vec(v));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_in++;
    endtask

    // source
    initial begin
        t_vec_in v;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_data    = '0;
        stim_done = 1'b0;
        hold_sink = 1'b0;
        no_idle   = 1'b0;
        beats_in  = 0;
        fill_table();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < N_DIRECTED; k++) send_beat(dir_vec[k]);
        i_valid <= 1'b0;
        // pause until the pipe drains
        while (expected_q.size() != 0) @(posedge i_clk);
        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle   <= (n >= 200 && n < 300);
            hold_sink <= (n == 400);
            v.comp_x = rand_comp();
            v.comp_y = rand_comp();
            v.comp_z = rand_comp();
            send_beat(v);
        end
        i_valid   <= 1'b0;
        stim_done <= 1'b1;
    end

    // sink: random stalls, plus one long hold-off to back the pipe up
    initial begin
        int hold_left;
        i_ready   = 1'b0;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_sink && hold_left == 0) hold_left = 3 * LATENCY;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= no_idle || ($urandom_range(0, 99) >= 13);
            end
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // result checking
    initial begin
        t_vec_out want;
        err_count  = 0;
        beats_out  = 0;
        zero_count = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    err_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (beats_out < N_DIRECTED && dir_known[beats_out]
                            && want !== dir_res[beats_out]) begin
                        $error("table row %0d disagrees with predictor", beats_out);
                        err_count++;
                    end
                    check_field("unit_x", want.unit_x, o_data.unit_x);
                    check_field("unit_y", want.unit_y, o_data.unit_y);
                    check_field("unit_z", want.unit_z, o_data.unit_z);
                    check_field("vec_length", want.vec_length, o_data.vec_length);
                    check_field("zero_length", want.zero_length, o_data.zero_length);
                    if (want.zero_length) zero_count++;
                end
                beats_out++;
            end
        end
    end

    // end of run and watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (stim_done && expected_q.size() == 0) begin
                repeat (LATENCY + 10) @(posedge i_clk);
                if (expected_q.size() != 0) begin
                    $error("%0d results still expected", expected_q.size());
                    err_count++;
                end
                $display("%0d vectors sent, %0d results checked (%0d zero vectors)",
                         beats_in, beats_out, zero_count);
                $display("covered extremes, signs, zero vectors, random stalls, long back-pressure");
                if (err_count == 0) begin
                    $display("SCOREBOARD CLEAN");
                end else begin
                    $display("SCOREBOARD MISMATCH");
                end
                $finish;
            end
        end
    end

endmodule

### vector3_normalize_unit.f
rtl/core/nrm_pkg.sv
rtl/core/nrm_sqrt_cell.sv
rtl/core/nrm_div_cell.sv
rtl/core/vector3_normalize_unit.sv
rtl/core/nrm_checker.sv
tb/tb_vector3_normalize_unit.sv
